// ===== rtl/fmf_pkg.sv =====
package fmf_pkg;

    // Internal operand width: 16-bit inputs plus a sign bit for the unsigned distance
    localparam int X_W = 17;

    localparam int FRAC_BITS_DEF = 8;

    // Distance breakpoints, Q12.4
    localparam int D35  = 560;
    localparam int D45  = 720;
    localparam int D52H = 840;
    localparam int D60  = 960;
    localparam int D70  = 1120;

    // Angle breakpoints, Q3.12 radians
    localparam int A_P12  = 1072;
    localparam int A_P6   = 2145;
    localparam int A_P4   = 3217;
    localparam int A_P3   = 4289;
    localparam int A_5P12 = 5362;
    localparam int A_P2   = 6434;

endpackage

// ===== rtl/fmf_ratio.sv =====
// q = min(1.0, round_half_up(n / DEN)), n assumed in [0, DEN)
// Constant divide done as multiply by ceil(2^SHIFT / DEN) and a shift.
module fmf_ratio #(
    parameter int FRAC_BITS = fmf_pkg::FRAC_BITS_DEF,
    parameter int DEN       = 160
) (
    input  logic [$clog2(DEN):0] i_n,
    output logic [FRAC_BITS:0]   o_q
);

    localparam int NW    = $clog2(DEN) + 1;
    localparam int NUM_W = NW + FRAC_BITS + 1;
    localparam int SHIFT = NUM_W + $clog2(DEN);
    localparam int MW    = NUM_W + 2;
    localparam int PW    = NUM_W + MW;
    localparam int QW    = PW - SHIFT;
    localparam logic [MW-1:0] MULT =
        MW'(((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN));
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic [NUM_W-1:0] num;
    logic [PW-1:0]    prod;
    logic [QW-1:0]    quo;

    always_comb begin
        num  = (NUM_W'(i_n) << FRAC_BITS) + NUM_W'(DEN / 2);
        prod = PW'(num) * PW'(MULT);
        quo  = prod[PW-1:SHIFT];
        if (quo > ONE_Q) begin
            o_q = ONE_Q[FRAC_BITS:0];
        end else begin
            o_q = quo[FRAC_BITS:0];
        end
    end

endmodule

// ===== rtl/fmf_shape.sv =====
// Trapezoid membership a <= b <= c <= d, with selectable value outside [a, d]
module fmf_shape #(
    parameter int FRAC_BITS = fmf_pkg::FRAC_BITS_DEF,
    parameter int A         = 0,
    parameter int B         = 0,
    parameter int C         = 0,
    parameter int D         = 0,
    parameter bit BELOW_ONE = 1'b0,
    parameter bit ABOVE_ONE = 1'b0
) (
    input  logic signed [fmf_pkg::X_W-1:0] i_x,
    output logic [FRAC_BITS:0]             o_mu
);

    localparam int XW    = fmf_pkg::X_W + 1;
    localparam int DEN_R = B - A;
    localparam int DEN_F = D - C;
    localparam int RW    = $clog2((DEN_R > 0) ? DEN_R : 1) + 1;
    localparam int FW    = $clog2((DEN_F > 0) ? DEN_F : 1) + 1;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic signed [XW-1:0] KA = XW'(A);
    localparam logic signed [XW-1:0] KB = XW'(B);
    localparam logic signed [XW-1:0] KC = XW'(C);
    localparam logic signed [XW-1:0] KD = XW'(D);

    logic signed [XW-1:0] x_ext;
    logic [FRAC_BITS:0]   q_r;
    logic [FRAC_BITS:0]   q_f;

    assign x_ext  = {i_x[fmf_pkg::X_W-1], i_x};

    generate
        if (DEN_R > 0) begin : g_rise
            logic signed [XW-1:0] diff_r;
            assign diff_r = x_ext - KA;
            fmf_ratio #(.FRAC_BITS(FRAC_BITS), .DEN(DEN_R)) u_rise (
                .i_n (diff_r[RW-1:0]),
                .o_q (q_r)
            );
        end else begin : g_rise_flat
            assign q_r = ONE;
        end
        if (DEN_F > 0) begin : g_fall
            logic signed [XW-1:0] diff_f;
            assign diff_f = KD - x_ext;
            fmf_ratio #(.FRAC_BITS(FRAC_BITS), .DEN(DEN_F)) u_fall (
                .i_n (diff_f[FW-1:0]),
                .o_q (q_f)
            );
        end else begin : g_fall_flat
            assign q_f = ONE;
        end
    endgenerate

    always_comb begin
        if (x_ext < KA) begin
            o_mu = BELOW_ONE ? ONE : '0;
        end else if (x_ext > KD) begin
            o_mu = ABOVE_ONE ? ONE : '0;
        end else if (x_ext >= KB && x_ext <= KC) begin
            o_mu = ONE;
        end else if (x_ext < KB) begin
            o_mu = q_r;
        end else begin
            o_mu = q_f;
        end
    end

endmodule

// ===== rtl/fuzzy_membership_fuzzifier.sv =====
// Stages: the start beat is taken into the input register, then the degrees are taken into
// the result register together with o_strobe.
// Throughput: one beat per cycle; busy is always low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears only the valid flags; no other state.
module fuzzy_membership_fuzzifier #(
    parameter int MEMBERSHIP_FRAC_BITS = fmf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [15:0]                   i_distance,
    input  logic signed [15:0]            i_heading_error,
    output logic                          busy,
    output logic                          o_strobe,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_dist_very_near,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_dist_near,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_dist_far,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_extreme_left,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_far_left,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_left,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_center,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_right,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_far_right,
    output logic [MEMBERSHIP_FRAC_BITS:0] o_head_extreme_right
);

    localparam int F  = MEMBERSHIP_FRAC_BITS;
    localparam int XW = fmf_pkg::X_W;
    localparam int NS = 10;

    logic                 r_in_vld;
    logic signed [XW-1:0] r_dist;
    logic signed [XW-1:0] r_head;
    logic                 r_strobe;
    logic [F:0]           r_mu [NS];
    logic [F:0]           n_mu [NS];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_in_vld <= start;
            r_strobe <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_dist <= {1'b0, i_distance};
            r_head <= {i_heading_error[15], i_heading_error};
        end
        if (r_in_vld) begin
            r_mu <= n_mu;
        end
    end

    fmf_shape #(.FRAC_BITS(F), .A(fmf_pkg::D35), .B(fmf_pkg::D35), .C(fmf_pkg::D35),
                .D(fmf_pkg::D45), .BELOW_ONE(1'b1), .ABOVE_ONE(1'b0))
        u_very_near (.i_x(r_dist), .o_mu(n_mu[0]));
    fmf_shape #(.FRAC_BITS(F), .A(fmf_pkg::D35), .B(fmf_pkg::D52H), .C(fmf_pkg::D52H),
                .D(fmf_pkg::D70), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b0))
        u_near (.i_x(r_dist), .o_mu(n_mu[1]));
    fmf_shape #(.FRAC_BITS(F), .A(fmf_pkg::D60), .B(fmf_pkg::D70), .C(fmf_pkg::D70),
                .D(fmf_pkg::D70), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b1))
        u_far (.i_x(r_dist), .o_mu(n_mu[2]));

    fmf_shape #(.FRAC_BITS(F), .A(fmf_pkg::A_P3), .B(fmf_pkg::A_P2), .C(fmf_pkg::A_P2),
                .D(fmf_pkg::A_P2), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b1))
        u_ext_left (.i_x(r_head), .o_mu(n_mu[3]));
    fmf_shape #(.FRAC_BITS(F), .A(fmf_pkg::A_P6), .B(fmf_pkg::A_P4), .C(fmf_pkg::A_P3),
                .D(fmf_pkg::A_5P12), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b0))
        u_far_left (.i_x(r_head), .o_mu(n_mu[4]));
    fmf_shape #(.FRAC_BITS(F), .A(0), .B(fmf_pkg::A_P12), .C(fmf_pkg::A_P6),
                .D(fmf_pkg::A_P4), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b0))
        u_left (.i_x(r_head), .o_mu(n_mu[5]));
    fmf_shape #(.FRAC_BITS(F), .A(-fmf_pkg::A_P12), .B(0), .C(0),
                .D(fmf_pkg::A_P12), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b0))
        u_center (.i_x(r_head), .o_mu(n_mu[6]));
    fmf_shape #(.FRAC_BITS(F), .A(-fmf_pkg::A_P4), .B(-fmf_pkg::A_P6), .C(-fmf_pkg::A_P12),
                .D(0), .BELOW_ONE(1'b0), .ABOVE_ONE(1'b0))
        u_right (.i_x(r_head), .o_mu(n_mu[7]));
    fmf_shape #(.FRAC_BITS(F), .A(-fmf_pkg::A_5P12), .B(-fmf_pkg::A_P3),
                .C(-fmf_pkg::A_P4), .D(-fmf_pkg::A_P6), .BELOW_ONE(1'b0),
                .ABOVE_ONE(1'b0))
        u_far_right (.i_x(r_head), .o_mu(n_mu[8]));
    fmf_shape #(.FRAC_BITS(F), .A(-fmf_pkg::A_P2), .B(-fmf_pkg::A_P2), .C(-fmf_pkg::A_P2),
                .D(-fmf_pkg::A_P3), .BELOW_ONE(1'b1), .ABOVE_ONE(1'b0))
        u_ext_right (.i_x(r_head), .o_mu(n_mu[9]));

    assign o_strobe             = r_strobe;
    assign o_dist_very_near     = r_mu[0];
    assign o_dist_near          = r_mu[1];
    assign o_dist_far           = r_mu[2];
    assign o_head_extreme_left  = r_mu[3];
    assign o_head_far_left      = r_mu[4];
    assign o_head_left          = r_mu[5];
    assign o_head_center        = r_mu[6];
    assign o_head_right         = r_mu[7];
    assign o_head_far_right     = r_mu[8];
    assign o_head_extreme_right = r_mu[9];

endmodule

// ===== tb/tb_fuzzy_membership_fuzzifier.sv =====
`timescale 1ns / 1ps

module tb_fuzzy_membership_fuzzifier;

    localparam int FB     = fmf_pkg::FRAC_BITS_DEF;
    localparam int ONE    = 1 << FB;
    localparam int N_SETS = 10;
    localparam int N_RAND = 1500;

    localparam int D35    = fmf_pkg::D35;
    localparam int D45    = fmf_pkg::D45;
    localparam int D52H   = fmf_pkg::D52H;
    localparam int D60    = fmf_pkg::D60;
    localparam int D70    = fmf_pkg::D70;
    localparam int A_P12  = fmf_pkg::A_P12;
    localparam int A_P6   = fmf_pkg::A_P6;
    localparam int A_P4   = fmf_pkg::A_P4;
    localparam int A_P3   = fmf_pkg::A_P3;
    localparam int A_5P12 = fmf_pkg::A_5P12;
    localparam int A_P2   = fmf_pkg::A_P2;

    typedef enum int {
        DIST_VERY_NEAR,
        DIST_NEAR,
        DIST_FAR,
        HEAD_EXTREME_LEFT,
        HEAD_FAR_LEFT,
        HEAD_LEFT,
        HEAD_CENTER,
        HEAD_RIGHT,
        HEAD_FAR_RIGHT,
        HEAD_EXTREME_RIGHT
    } t_mset;

    typedef logic [FB:0] t_degree;

    typedef struct packed {
        logic [15:0]                dist_in;
        logic [15:0]                head;
        logic [N_SETS-1:0][FB:0]    deg;
    } t_degree_set;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic [15:0]    i_distance;
    logic signed [15:0] i_heading_error;
    logic           busy;
    logic           o_strobe;
    t_degree        o_dist_very_near;
    t_degree        o_dist_near;
    t_degree        o_dist_far;
    t_degree        o_head_extreme_left;
    t_degree        o_head_far_left;
    t_degree        o_head_left;
    t_degree        o_head_center;
    t_degree        o_head_right;
    t_degree        o_head_far_right;
    t_degree        o_head_extreme_right;

    t_degree_set    pending_degrees[$];
    int             mismatch_count = 0;
    bit             idle_en = 1'b1;

    int dist_knots[5]  = '{D35, D45, D52H, D60, D70};
    int head_knots[13] = '{0, A_P12, -A_P12, A_P6, -A_P6, A_P4, -A_P4,
                           A_P3, -A_P3, A_5P12, -A_5P12, A_P2, -A_P2};

    fuzzy_membership_fuzzifier i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .i_distance          (i_distance),
        .i_heading_error     (i_heading_error),
        .busy                (busy),
        .o_strobe            (o_strobe),
        .o_dist_very_near    (o_dist_very_near),
        .o_dist_near         (o_dist_near),
        .o_dist_far          (o_dist_far),
        .o_head_extreme_left (o_head_extreme_left),
        .o_head_far_left     (o_head_far_left),
        .o_head_left         (o_head_left),
        .o_head_center       (o_head_center),
        .o_head_right        (o_head_right),
        .o_head_far_right    (o_head_far_right),
        .o_head_extreme_right(o_head_extreme_right)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Rounded ratio n/den in Q1.FB, half up, clipped to one
    function automatic t_degree slope_degree(input int n, input int den);
        int r;
        if (n <= 0) return '0;
        r = ((n << FB) + den / 2) / den;
        return (r > ONE) ? t_degree'(ONE) : t_degree'(r);
    endfunction

    function automatic t_degree trapezoid(input int x, input int a, input int b,
                                          input int c, input int d,
                                          input bit below_one, input bit above_one);
        if (x < a) return below_one ? t_degree'(ONE) : '0;
        if (x > d) return above_one ? t_degree'(ONE) : '0;
        if (x >= b && x <= c) return t_degree'(ONE);
        if (x < b) return slope_degree(x - a, b - a);
        return slope_degree(d - x, d - c);
    endfunction

    function automatic t_degree_set fuzzify(input logic [15:0] dist_in,
                                            input logic [15:0] head);
        t_degree_set r;
        int x;
        int h;
        x = int'(dist_in);
        h = int'($signed(head));
        r.dist_in = dist_in;
        r.head = head;
        r.deg[DIST_VERY_NEAR]     = trapezoid(x, D35, D35, D35, D45, 1'b1, 1'b0);
        r.deg[DIST_NEAR]          = trapezoid(x, D35, D52H, D52H, D70, 1'b0, 1'b0);
        r.deg[DIST_FAR]           = trapezoid(x, D60, D70, D70, D70, 1'b0, 1'b1);
        r.deg[HEAD_EXTREME_LEFT]  = trapezoid(h, A_P3, A_P2, A_P2, A_P2, 1'b0, 1'b1);
        r.deg[HEAD_FAR_LEFT]      = trapezoid(h, A_P6, A_P4, A_P3, A_5P12, 1'b0, 1'b0);
        r.deg[HEAD_LEFT]          = trapezoid(h, 0, A_P12, A_P6, A_P4, 1'b0, 1'b0);
        r.deg[HEAD_CENTER]        = trapezoid(h, -A_P12, 0, 0, A_P12, 1'b0, 1'b0);
        r.deg[HEAD_RIGHT]         = trapezoid(h, -A_P4, -A_P6, -A_P12, 0, 1'b0, 1'b0);
        r.deg[HEAD_FAR_RIGHT]     = trapezoid(h, -A_5P12, -A_P3, -A_P4, -A_P6, 1'b0, 1'b0);
        r.deg[HEAD_EXTREME_RIGHT] = trapezoid(h, -A_P2, -A_P2, -A_P2, -A_P3, 1'b1, 1'b0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // Called just after a rising edge; returns just after the edge that took the beat
    task automatic send_beat(input logic [15:0] dist_in, input logic [15:0] head);
        while (idle_en && $urandom_range(99) < 23) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_distance      <= dist_in;
        i_heading_error <= head;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_degrees.push_back(fuzzify(dist_in, head));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_degrees.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_distance();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                v = dist_knots[$urandom_range(4)] + int'($urandom_range(40)) - 20;
                return 16'(v);
            end
            4, 5, 6: return 16'($urandom_range(1300));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_heading();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                v = head_knots[$urandom_range(12)] + int'($urandom_range(40)) - 20;
                return 16'(v);
            end
            4, 5, 6: return 16'(int'($urandom_range(14000)) - 7000);
            default: return 16'($urandom);
        endcase
    endfunction

    // Breakpoints, slope feet, plateau edges and the ends of both ranges
    task automatic test_breakpoints();
        int dl[20] = '{0, 559, 560, 561, 719, 720, 721, 839, 840, 841,
                       959, 960, 961, 1119, 1120, 1121, 65535, 32768, 700, 1000};
        int hl[20] = '{0, 1072, -1072, 2145, -2145, 3217, -3217, 4289, -4289,
                       5362, -5362, 6434, -6434, 6435, -6435, 32767, -32768,
                       1, -1, 4288};
        for (int i = 0; i < 20; i++)
            send_beat(16'(dl[i]), 16'(hl[i]));
        for (int i = 0; i < 4; i++)
            send_beat(16'($urandom), 16'(hl[$urandom_range(19)]));
    endtask

    task automatic test_random_beats(input int count);
        for (int i = 0; i < count; i++)
            send_beat(pick_distance(), pick_heading());
    endtask

    // Back-to-back beats, start held high throughout
    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        test_random_beats(count);
        idle_en = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        wait_drained();
        test_random_beats(20);
    endtask

    always @(posedge i_clk) begin : result_check
        t_degree_set             exp_set;
        logic [N_SETS-1:0][FB:0] got;
        t_mset                   s;
        if (i_rst_n === 1'b1 && $isunknown(o_strobe)) begin
            report_mismatch("strobe unknown after reset");
        end else if (i_rst_n === 1'b1 && o_strobe) begin
            got[DIST_VERY_NEAR]     = o_dist_very_near;
            got[DIST_NEAR]          = o_dist_near;
            got[DIST_FAR]           = o_dist_far;
            got[HEAD_EXTREME_LEFT]  = o_head_extreme_left;
            got[HEAD_FAR_LEFT]      = o_head_far_left;
            got[HEAD_LEFT]          = o_head_left;
            got[HEAD_CENTER]        = o_head_center;
            got[HEAD_RIGHT]         = o_head_right;
            got[HEAD_FAR_RIGHT]     = o_head_far_right;
            got[HEAD_EXTREME_RIGHT] = o_head_extreme_right;
            if (pending_degrees.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                exp_set = pending_degrees.pop_front();
                for (int i = 0; i < N_SETS; i++) begin
                    s = t_mset'(i);
                    if (got[i] !== exp_set.deg[i])
                        report_mismatch($sformatf("%s got %0d exp %0d (dist %0d head %0d)",
                            s.name(), got[i], exp_set.deg[i], exp_set.dist_in,
                            $signed(exp_set.head)));
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_distance      <= '0;
        i_heading_error <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_breakpoints();
        test_random_beats(N_RAND / 2);
        test_pause_until_drained();
        test_back_to_back(300);
        test_random_beats(N_RAND / 2 - 320);

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
